[rtl/pdp_pkg.sv]
// Package for the packet header digest parser: constants, flag positions and shared types.
`default_nettype none
package pdp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int OFFSET_W = 16;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 16'hFFFF;

  localparam logic [15:0] MIN_ETHERTYPE = 16'd1500;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [31:0] TEST_NET = 32'hC000_0200;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [5:0] IP_MIN_HLEN = 6'd20;

  // Bit positions in proto_flags.
  localparam int F_SLL = 0;
  localparam int F_ETH = 1;
  localparam int F_IP4 = 2;
  localparam int F_TCP = 3;
  localparam int F_UDP = 4;
  localparam int F_ICMP = 5;
  localparam int F_TRUNC = 6;
  localparam int F_TERM = 7;
  localparam int F_UNK = 8;

  // Configuration register indexes.
  localparam logic REG_LINK_KIND = 1'b0;

  typedef enum logic [4:0] {
    L_LINK = 5'b00001,
    L_IP4  = 5'b00010,
    L_TCP  = 5'b00100,
    L_UDP  = 5'b01000,
    L_DONE = 5'b10000
  } layer_t;

  // One frame byte as the front end tags it.
  typedef struct packed {
    logic [7:0]          frame_byte;
    logic                frame_end;
    logic                link_kind;
    logic [OFFSET_W-1:0] offset;
  } byte_entry_t;

  typedef struct packed {
    logic [8:0]  proto_flags;
    logic [47:0] mac_dest;
    logic [47:0] mac_src;
    logic [15:0] link_ethertype;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] port_src;
    logic [15:0] port_dst;
  } digest_t;

endpackage
`default_nettype wire

[rtl/pdp_byte_if.sv]
// Stream interface that carries frame bytes.
`default_nettype none
interface pdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source(output valid, output frame_byte, output frame_end, input ready);
  modport sink(input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

[rtl/pdp_digest_if.sv]
// Stream interface that carries one header digest per frame.
`default_nettype none
interface pdp_digest_if;
  logic        valid;
  logic        ready;
  logic [8:0]  proto_flags;
  logic [47:0] mac_dest;
  logic [47:0] mac_src;
  logic [15:0] link_ethertype;
  logic [31:0] ip_src;
  logic [31:0] ip_dst;
  logic [15:0] port_src;
  logic [15:0] port_dst;

  modport source(output valid, output proto_flags, output mac_dest, output mac_src,
                 output link_ethertype, output ip_src, output ip_dst, output port_src,
                 output port_dst, input ready);
  modport sink(input valid, input proto_flags, input mac_dest, input mac_src,
               input link_ethertype, input ip_src, input ip_dst, input port_src,
               input port_dst, output ready);
endinterface
`default_nettype wire

[rtl/packet_header_digest_parser.sv]
// The last frame byte passes through the byte queue; the digest is then registered.
// Throughput: one byte per cycle unless a frame-end byte waits for a full output register.
// A new frame's bytes are taken while the previous digest waits in the output register.
// Reset (rst, synchronous) empties the queue, clears all frame state and sets link_kind to 0.
// No clearing pass is needed after reset.
`default_nettype none
module packet_header_digest_parser #(
  parameter int QUEUE_DEPTH = pdp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pdp_byte_if.sink         frames,
  pdp_digest_if.source     digests,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic link_kind;
  logic queue_full;
  logic push;
  logic pop;
  logic head_valid;
  pdp_pkg::byte_entry_t push_entry;
  pdp_pkg::byte_entry_t head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == pdp_pkg::REG_LINK_KIND
                 && paddr[1:0] == 2'b00) begin
      link_kind <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[2] == pdp_pkg::REG_LINK_KIND && paddr[1:0] == 2'b00) begin
      prdata = {31'd0, link_kind};
    end else begin
      prdata = '0;
    end
  end

  pdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frames     (frames),
    .link_kind  (link_kind),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  pdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pdp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .digests    (digests)
  );

endmodule
`default_nettype wire

[rtl/pdp_front.sv]
// Front end: accepts frame bytes and tags each with its frame offset and link kind.
`default_nettype none
module pdp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  pdp_byte_if.sink                frames,
  input  wire logic               link_kind,
  input  wire logic               queue_full,
  output logic                    push,
  output pdp_pkg::byte_entry_t    entry
);

  logic [pdp_pkg::OFFSET_W-1:0] offset;
  logic [pdp_pkg::OFFSET_W-1:0] offset_next;

  assign frames.ready = !queue_full;
  assign push = frames.valid && !queue_full;

  assign entry.frame_byte = frames.frame_byte;
  assign entry.frame_end = frames.frame_end;
  assign entry.link_kind = link_kind;
  assign entry.offset = offset;

  // The offset stops at its maximum on very long frames.
  always_comb begin
    if (frames.frame_end) begin
      offset_next = '0;
    end else if (offset == pdp_pkg::OFFSET_MAX) begin
      offset_next = offset;
    end else begin
      offset_next = offset + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (push) begin
      offset <= offset_next;
    end
  end

endmodule
`default_nettype wire

[rtl/pdp_queue.sv]
// Short queue of tagged bytes between the front end and the parser.
`default_nettype none
module pdp_queue #(
  parameter int DEPTH = pdp_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  pdp_pkg::byte_entry_t    push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output pdp_pkg::byte_entry_t    head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  pdp_pkg::byte_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pdp_parse.sv]
// Back end: parses header bytes one per cycle unless stalled; registers digest.
`default_nettype none
module pdp_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  pdp_pkg::byte_entry_t    head,
  output logic                    pop,
  pdp_digest_if.source            digests
);

  pdp_pkg::layer_t layer, layer_n;
  logic [15:0] layer_start, start_n;
  logic [5:0]  ip_hlen, ip_hlen_n;
  logic [7:0]  ip_proto, ip_proto_n;
  logic        ver_ok, ver_ok_n;
  logic [8:0]  flags, flags_n;
  logic [47:0] mac_dest, mac_dest_n;
  logic [47:0] mac_src, mac_src_n;
  logic [15:0] ethertype, ethertype_n;
  logic [31:0] ip_src, ip_src_n;
  logic [31:0] ip_dst, ip_dst_n;
  logic [31:0] ports, ports_n;

  logic        out_valid;
  pdp_pkg::digest_t out_reg, fin;

  logic        slot_free;
  logic [15:0] rel;
  logic [15:0] off_next;
  logic [15:0] seen;
  logic        link_done;
  logic        go_transport;
  logic [4:0]  l4_hlen;
  logic [7:0]  b;

  assign slot_free = !out_valid || digests.ready;
  assign pop = head_valid && (!head.frame_end || slot_free);
  assign b = head.frame_byte;

  always_comb begin
    rel = head.offset - layer_start;
    off_next = (head.offset == pdp_pkg::OFFSET_MAX) ? head.offset : head.offset + 16'd1;
    layer_n = layer;
    start_n = layer_start;
    ip_hlen_n = ip_hlen;
    ip_proto_n = ip_proto;
    ver_ok_n = ver_ok;
    flags_n = flags;
    mac_dest_n = mac_dest;
    mac_src_n = mac_src;
    ethertype_n = ethertype;
    ip_src_n = ip_src;
    ip_dst_n = ip_dst;
    ports_n = ports;
    link_done = 1'b0;
    go_transport = 1'b0;
    l4_hlen = (layer == pdp_pkg::L_TCP) ? 5'd20 : 5'd8;

    case (layer)
      pdp_pkg::L_LINK: begin
        if (!head.link_kind) begin
          if (rel < 16'd6) begin
            mac_dest_n = {mac_dest[39:0], b};
          end else if (rel < 16'd12) begin
            mac_src_n = {mac_src[39:0], b};
          end else if (rel < 16'd14) begin
            ethertype_n = {ethertype[7:0], b};
          end
          link_done = (rel == 16'd13);
        end else begin
          if (rel >= 16'd14 && rel < 16'd16) begin
            ethertype_n = {ethertype[7:0], b};
          end
          link_done = (rel == 16'd15);
        end
        if (link_done) begin
          if (head.link_kind && ethertype_n <= pdp_pkg::MIN_ETHERTYPE) begin
            flags_n[pdp_pkg::F_UNK] = 1'b1;
            layer_n = pdp_pkg::L_DONE;
          end else if (ethertype_n == pdp_pkg::ETHERTYPE_IPV4) begin
            start_n = off_next;
            layer_n = pdp_pkg::L_IP4;
            flags_n[pdp_pkg::F_IP4] = 1'b1;
          end else begin
            layer_n = pdp_pkg::L_DONE;
          end
        end
      end
      pdp_pkg::L_IP4: begin
        if (rel == 16'd0) begin
          ver_ok_n = (b[7:4] == pdp_pkg::IP_VERSION);
          ip_hlen_n = {b[3:0], 2'b00};
        end else if (rel == 16'd9) begin
          ip_proto_n = b;
        end else if (rel >= 16'd12 && rel < 16'd16) begin
          ip_src_n = {ip_src[23:0], b};
        end else if (rel >= 16'd16 && rel < 16'd20) begin
          ip_dst_n = {ip_dst[23:0], b};
        end
        if (rel == 16'd19) begin
          if (!ver_ok) begin
            flags_n[pdp_pkg::F_UNK] = 1'b1;
            ip_src_n = pdp_pkg::TEST_NET;
            ip_dst_n = pdp_pkg::TEST_NET;
            layer_n = pdp_pkg::L_DONE;
          end else if (ip_hlen < pdp_pkg::IP_MIN_HLEN) begin
            flags_n[pdp_pkg::F_UNK] = 1'b1;
            layer_n = pdp_pkg::L_DONE;
          end else if (ip_hlen == pdp_pkg::IP_MIN_HLEN) begin
            go_transport = 1'b1;
          end
        end else if (rel > 16'd19 && ({1'b0, rel} + 17'd1) == {11'd0, ip_hlen}) begin
          go_transport = 1'b1;
        end
      end
      pdp_pkg::L_TCP, pdp_pkg::L_UDP: begin
        if (rel < 16'd4) begin
          ports_n = {ports[23:0], b};
        end
        if (rel == {11'd0, l4_hlen - 5'd1}) begin
          flags_n[pdp_pkg::F_TERM] = 1'b1;
          layer_n = pdp_pkg::L_DONE;
        end
      end
      default: begin
      end
    endcase

    if (go_transport) begin
      case (ip_proto)
        pdp_pkg::PROTO_TCP: begin
          start_n = off_next;
          layer_n = pdp_pkg::L_TCP;
          flags_n[pdp_pkg::F_TCP] = 1'b1;
        end
        pdp_pkg::PROTO_UDP: begin
          start_n = off_next;
          layer_n = pdp_pkg::L_UDP;
          flags_n[pdp_pkg::F_UDP] = 1'b1;
        end
        pdp_pkg::PROTO_ICMP: begin
          flags_n[pdp_pkg::F_ICMP] = 1'b1;
          flags_n[pdp_pkg::F_TERM] = 1'b1;
          layer_n = pdp_pkg::L_DONE;
        end
        default: layer_n = pdp_pkg::L_DONE;
      endcase
    end

    // Close the digest as if the frame ended after this byte.
    seen = off_next - start_n;
    fin.proto_flags = flags_n;
    fin.mac_dest = mac_dest_n;
    fin.mac_src = mac_src_n;
    fin.link_ethertype = ethertype_n;
    fin.ip_src = ip_src_n;
    fin.ip_dst = ip_dst_n;
    fin.port_src = ports_n[31:16];
    fin.port_dst = ports_n[15:0];
    case (layer_n)
      pdp_pkg::L_LINK: begin
        fin.proto_flags[pdp_pkg::F_TRUNC] = 1'b1;
        fin.mac_dest = '0;
        fin.mac_src = '0;
        fin.link_ethertype = '0;
      end
      pdp_pkg::L_IP4: begin
        if (seen < 16'd20) begin
          fin.proto_flags[pdp_pkg::F_TRUNC] = 1'b1;
          fin.ip_src = pdp_pkg::TEST_NET;
          fin.ip_dst = pdp_pkg::TEST_NET;
        end else begin
          case (ip_proto_n)
            pdp_pkg::PROTO_TCP: begin
              fin.proto_flags[pdp_pkg::F_TCP] = 1'b1;
              fin.proto_flags[pdp_pkg::F_TRUNC] = 1'b1;
              fin.port_src = '0;
              fin.port_dst = '0;
            end
            pdp_pkg::PROTO_UDP: begin
              fin.proto_flags[pdp_pkg::F_UDP] = 1'b1;
              fin.proto_flags[pdp_pkg::F_TRUNC] = 1'b1;
              fin.port_src = '0;
              fin.port_dst = '0;
            end
            pdp_pkg::PROTO_ICMP: begin
              fin.proto_flags[pdp_pkg::F_ICMP] = 1'b1;
              fin.proto_flags[pdp_pkg::F_TERM] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pdp_pkg::L_TCP, pdp_pkg::L_UDP: begin
        fin.proto_flags[pdp_pkg::F_TRUNC] = 1'b1;
        fin.port_src = '0;
        fin.port_dst = '0;
      end
      default: begin
      end
    endcase
    if (head.link_kind) begin
      fin.proto_flags[pdp_pkg::F_SLL] = 1'b1;
    end else begin
      fin.proto_flags[pdp_pkg::F_ETH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head.frame_end)) begin
      layer <= pdp_pkg::L_LINK;
      layer_start <= '0;
      ip_hlen <= '0;
      ip_proto <= '0;
      ver_ok <= 1'b0;
      flags <= '0;
      mac_dest <= '0;
      mac_src <= '0;
      ethertype <= '0;
      ip_src <= '0;
      ip_dst <= '0;
      ports <= '0;
    end else if (pop) begin
      layer <= layer_n;
      layer_start <= start_n;
      ip_hlen <= ip_hlen_n;
      ip_proto <= ip_proto_n;
      ver_ok <= ver_ok_n;
      flags <= flags_n;
      mac_dest <= mac_dest_n;
      mac_src <= mac_src_n;
      ethertype <= ethertype_n;
      ip_src <= ip_src_n;
      ip_dst <= ip_dst_n;
      ports <= ports_n;
    end
  end

  // Output register: a new digest may load in the cycle the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.frame_end) begin
      out_valid <= 1'b1;
    end else if (digests.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.frame_end) begin
      out_reg <= fin;
    end
  end

  assign digests.valid = out_valid;
  assign digests.proto_flags = out_reg.proto_flags;
  assign digests.mac_dest = out_reg.mac_dest;
  assign digests.mac_src = out_reg.mac_src;
  assign digests.link_ethertype = out_reg.link_ethertype;
  assign digests.ip_src = out_reg.ip_src;
  assign digests.ip_dst = out_reg.ip_dst;
  assign digests.port_src = out_reg.port_src;
  assign digests.port_dst = out_reg.port_dst;

endmodule
`default_nettype wire

[bench/packet_header_digest_parser_tb.sv]
// Self-checking testbench for the packet header digest parser: directed and random frames.
`default_nettype none
module packet_header_digest_parser_tb;
  import pdp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int IHL_UNIT = 4;
  localparam int RANDOM_FILL = -1;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] LINK_KIND_ADDR = 3'(4 * int'(REG_LINK_KIND));

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pdp_byte_if fb();
  pdp_digest_if dg();

  packet_header_digest_parser uut (
    .clk(clk),
    .rst(rst),
    .frames(fb),
    .digests(dg),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Parser state as the testbench tracks it.
  logic link_mode;
  layer_t cur_layer;
  logic [15:0] offs;
  logic [15:0] lstart;
  int ihl_bytes;
  logic [7:0] ip_proto;
  logic [8:0] flg;
  logic [47:0] dmac;
  logic [47:0] smac;
  logic [15:0] etype;
  logic [31:0] sip;
  logic [31:0] dip;
  logic [31:0] ports;
  bit version_ok;

  digest_t pending_digests[$];
  int errors;
  int bytes_sent;
  int frames_sent;
  bit tx_steady;
  bit rx_steady;
  digest_t got;
  digest_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_frame_state();
    cur_layer = L_LINK;
    offs = '0;
    lstart = '0;
    ihl_bytes = 0;
    ip_proto = '0;
    flg = '0;
    dmac = '0;
    smac = '0;
    etype = '0;
    sip = '0;
    dip = '0;
    ports = '0;
    version_ok = 1'b0;
  endfunction

  function automatic void open_layer(layer_t l, int flag_bit);
    lstart = (offs != OFFSET_MAX) ? offs + 16'd1 : OFFSET_MAX;
    cur_layer = l;
    flg[flag_bit] = 1'b1;
  endfunction

  function automatic void open_transport();
    case (ip_proto)
      PROTO_TCP: open_layer(L_TCP, F_TCP);
      PROTO_UDP: open_layer(L_UDP, F_UDP);
      PROTO_ICMP: begin
        flg[F_ICMP] = 1'b1;
        flg[F_TERM] = 1'b1;
        cur_layer = L_DONE;
      end
      default: cur_layer = L_DONE;
    endcase
  endfunction

  function automatic void close_link();
    if (link_mode && etype <= MIN_ETHERTYPE) begin
      flg[F_UNK] = 1'b1;
      cur_layer = L_DONE;
    end else if (etype == ETHERTYPE_IPV4) begin
      open_layer(L_IP4, F_IP4);
    end else begin
      cur_layer = L_DONE;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, int rel);
    int hlen;
    case (cur_layer)
      L_LINK: begin
        if (!link_mode) begin
          if (rel < 6) dmac = {dmac[39:0], b};
          else if (rel < 12) smac = {smac[39:0], b};
          else if (rel < 14) etype = {etype[7:0], b};
          if (rel == 13) close_link();
        end else begin
          if (rel >= 14 && rel < 16) etype = {etype[7:0], b};
          if (rel == 15) close_link();
        end
      end
      L_IP4: begin
        if (rel == 0) begin
          version_ok = (b[7:4] == IP_VERSION);
          ihl_bytes = int'(b[3:0]) * IHL_UNIT;
        end else if (rel == 9) begin
          ip_proto = b;
        end else if (rel >= 12 && rel < 16) begin
          sip = {sip[23:0], b};
        end else if (rel >= 16 && rel < 20) begin
          dip = {dip[23:0], b};
        end
        if (rel == 19) begin
          if (!version_ok) begin
            flg[F_UNK] = 1'b1;
            sip = TEST_NET;
            dip = TEST_NET;
            cur_layer = L_DONE;
          end else if (ihl_bytes < int'(IP_MIN_HLEN)) begin
            flg[F_UNK] = 1'b1;
            cur_layer = L_DONE;
          end else if (ihl_bytes == int'(IP_MIN_HLEN)) begin
            open_transport();
          end
        end else if (rel > 19 && rel + 1 == ihl_bytes) begin
          open_transport();
        end
      end
      L_TCP, L_UDP: begin
        hlen = (cur_layer == L_TCP) ? 20 : 8;
        if (rel < 4) ports = {ports[23:0], b};
        if (rel + 1 == hlen) begin
          flg[F_TERM] = 1'b1;
          cur_layer = L_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // Advances the tracked parser by one accepted byte; queues a digest on the frame end.
  function automatic void track_byte(logic [7:0] b, logic last);
    logic [15:0] rel16;
    logic [15:0] seen;
    digest_t d;
    rel16 = offs - lstart;
    parse_byte(b, int'(rel16));
    if (offs != OFFSET_MAX) offs = offs + 16'd1;
    if (last) begin
      seen = offs - lstart;
      if (cur_layer == L_LINK) begin
        flg[F_TRUNC] = 1'b1;
        dmac = '0;
        smac = '0;
        etype = '0;
      end else if (cur_layer == L_IP4 && seen < 16'(IP_MIN_HLEN)) begin
        flg[F_TRUNC] = 1'b1;
        sip = TEST_NET;
        dip = TEST_NET;
      end else begin
        if (cur_layer == L_IP4) open_transport();
        if (cur_layer == L_TCP || cur_layer == L_UDP) begin
          flg[F_TRUNC] = 1'b1;
          ports = '0;
          cur_layer = L_DONE;
        end
      end
      d.proto_flags = flg;
      d.proto_flags[link_mode ? F_SLL : F_ETH] = 1'b1;
      d.mac_dest = dmac;
      d.mac_src = smac;
      d.link_ethertype = etype;
      d.ip_src = sip;
      d.ip_dst = dip;
      d.port_src = ports[31:16];
      d.port_dst = ports[15:0];
      pending_digests.push_back(d);
      clear_frame_state();
    end
  endfunction

  function automatic string show(digest_t d);
    return $sformatf("flags=%h dmac=%h smac=%h etype=%h ipsrc=%h ipdst=%h sport=%h dport=%h",
                     d.proto_flags, d.mac_dest, d.mac_src, d.link_ethertype, d.ip_src,
                     d.ip_dst, d.port_src, d.port_dst);
  endfunction

  // Compares every digest beat with the oldest expected digest.
  always @(posedge clk) begin
    if (!rst && dg.valid && dg.ready) begin
      got = {dg.proto_flags, dg.mac_dest, dg.mac_src, dg.link_ethertype, dg.ip_src,
             dg.ip_dst, dg.port_src, dg.port_dst};
      if (pending_digests.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected digest: %s", show(got));
      end else begin
        want = pending_digests.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("digest mismatch: expected %s", show(want));
            $display("                 actual   %s", show(got));
          end
        end
      end
    end
  end

  // Digest sink with random stalls and stretches of none.
  initial begin
    int hold;
    dg.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        dg.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      dg.ready <= 1'b1;
      do @(posedge clk); while (!(dg.valid && dg.ready));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      fb.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fb.valid <= 1'b1;
    fb.frame_byte <= b;
    fb.frame_end <= last;
    do @(posedge clk); while (!fb.ready);
    track_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t f, input bit steady);
    tx_steady = steady;
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // Lowers valid and waits until the block has handed over every digest.
  task automatic settle();
    fb.valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_link_kind(input logic v);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINK_KIND_ADDR;
    pwdata <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    link_mode = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, v}) begin
      errors++;
      if (errors <= MAX_REPORTS) $display("link_kind read back %h, expected %h", prdata, v);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick(int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // Builds a frame for the current link mode; cut > 0 shortens it to that many bytes.
  function automatic void make_frame(output byte_q_t f, input logic [15:0] et,
                                     input logic [7:0] ver_ihl, input logic [7:0] proto,
                                     input int tail, input int cut, input int fill);
    int n;
    f = {};
    n = link_mode ? 14 : 12;
    repeat (n) f.push_back(pick(fill));
    f.push_back(et[15:8]);
    f.push_back(et[7:0]);
    if (et == ETHERTYPE_IPV4) begin
      f.push_back(ver_ihl);
      for (int i = 1; i < 20; i++) f.push_back((i == 9) ? proto : pick(fill));
      if (ver_ihl[3:0] > 4'd5) repeat ((int'(ver_ihl[3:0]) - 5) * IHL_UNIT) f.push_back(pick(fill));
      n = (proto == PROTO_TCP) ? 20 : (proto == PROTO_UDP || proto == PROTO_ICMP) ? 8 : 0;
      repeat (n) f.push_back(pick(fill));
    end
    repeat (tail) f.push_back(pick(fill));
    if (cut > 0) while (f.size() > cut) void'(f.pop_back());
  endfunction

  task automatic frame_of(input logic [15:0] et, input logic [7:0] ver_ihl,
                          input logic [7:0] proto, input int tail, input int cut,
                          input int fill);
    byte_q_t f;
    make_frame(f, et, ver_ihl, proto, tail, cut, fill);
    send_frame(f, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_ethernet_layers();
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'hFF);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 3, 0, 8'h00);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 5, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 2, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, 8'd47, 4, 0, RANDOM_FILL);
    frame_of(16'h86DD, 8'h45, PROTO_TCP, 6, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h47, PROTO_TCP, 2, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, 1, 0, RANDOM_FILL);
  endtask

  task automatic test_truncation();
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 1, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 13, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 14, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 24, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 37, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 40, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 0, 34, RANDOM_FILL);
    // Options cut short: the transport layer starts with no bytes.
    frame_of(ETHERTYPE_IPV4, 8'h46, PROTO_TCP, 0, 36, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h48, PROTO_ICMP, 0, 38, RANDOM_FILL);
  endtask

  task automatic test_bad_ipv4();
    frame_of(ETHERTYPE_IPV4, 8'h65, PROTO_TCP, 2, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h43, PROTO_TCP, 2, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h40, PROTO_UDP, 0, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'hFF, PROTO_UDP, 0, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h65, PROTO_UDP, 0, 20, RANDOM_FILL);
  endtask

  task automatic test_cooked_link();
    write_link_kind(1'b1);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 3, 0, RANDOM_FILL);
    frame_of(MIN_ETHERTYPE, 8'h45, PROTO_UDP, 3, 0, RANDOM_FILL);
    frame_of(MIN_ETHERTYPE + 16'd1, 8'h45, PROTO_UDP, 3, 0, RANDOM_FILL);
    frame_of(16'h0000, 8'h45, PROTO_UDP, 0, 0, RANDOM_FILL);
    frame_of(16'hFFFF, 8'h45, PROTO_UDP, 0, 0, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 10, RANDOM_FILL);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 0, 8'hFF);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 0, 0, RANDOM_FILL);
    write_link_kind(1'b0);
  endtask

  // A frame longer than the offset counter can count.
  task automatic test_long_frame();
    byte_q_t f;
    make_frame(f, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 65600, 0, RANDOM_FILL);
    send_frame(f, 1'b1);
    frame_of(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 0, 0, RANDOM_FILL);
  endtask

  task automatic random_frame();
    logic [15:0] et;
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [7:0] proto;
    int pick_n;
    int cut;
    pick_n = $urandom_range(0, 99);
    if (pick_n < 80) et = ETHERTYPE_IPV4;
    else if (link_mode && pick_n < 90) et = 16'($urandom_range(0, int'(MIN_ETHERTYPE)));
    else et = 16'($urandom);
    ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_VERSION;
    pick_n = $urandom_range(0, 99);
    if (pick_n < 75) ihl = 4'd5;
    else if (pick_n < 90) ihl = 4'($urandom_range(6, 15));
    else ihl = 4'($urandom_range(0, 4));
    pick_n = $urandom_range(0, 99);
    if (pick_n < 30) proto = PROTO_TCP;
    else if (pick_n < 60) proto = PROTO_UDP;
    else if (pick_n < 75) proto = PROTO_ICMP;
    else proto = 8'($urandom);
    pick_n = $urandom_range(0, 99);
    if (pick_n < 20) cut = $urandom_range(1, 20);
    else if (pick_n < 40) cut = $urandom_range(1, 70);
    else cut = 0;
    frame_of(et, {ver, ihl}, proto, $urandom_range(0, 12), cut, RANDOM_FILL);
  endtask

  task automatic test_random_frames();
    int phase_start;
    int phase_frames;
    for (int phase = 0; phase < 4; phase++) begin
      write_link_kind(phase[0]);
      phase_start = bytes_sent;
      phase_frames = 0;
      while (bytes_sent - phase_start < 240 || phase_frames < 12) begin
        random_frame();
        phase_frames++;
      end
    end
  endtask

  initial begin
    #1500000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    errors = 0;
    bytes_sent = 0;
    frames_sent = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    link_mode = 1'b0;
    clear_frame_state();
    rst <= 1'b1;
    fb.valid <= 1'b0;
    fb.frame_byte <= '0;
    fb.frame_end <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ethernet_layers();
    test_truncation();
    // Let every digest drain before more frames go in.
    settle();
    test_bad_ipv4();
    test_cooked_link();
    test_long_frame();
    test_random_frames();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_digests.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
